### design/lags_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lags_pkg
// Shared widths, register indexes, window types and rule constants for the
// Life generation stream core.
// ----------------------------------------------------------------------------
package lags_pkg;

    localparam int DEF_MAX_COLS = 32;
    localparam int DEF_MAX_ROWS = 32;

    localparam int RST_COLS = 32;
    localparam int RST_ROWS = 32;

    localparam int COLS_W     = 6;
    localparam int ROWS_W     = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam int CELL_ROW_W = 12;
    localparam int CELL_COL_W = 6;
    localparam int LIVE_CNT_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd1;

    localparam int NBR_W = 4;
    localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

    // One window column: [0] upper row, [1] middle row, [2] lower row.
    typedef logic [2:0] col_t;
    // 3x3 window: [0] left column, [1] centre column, [2] right column.
    typedef col_t [2:0] win_t;

endpackage

### design/lags_rule.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lags_rule
// B3/S23 evaluation of the centre cell of a 3x3 neighbourhood window.
// ----------------------------------------------------------------------------
module lags_rule (
    input  lags_pkg::win_t win,
    output logic           alive
);
    import lags_pkg::*;

    logic [NBR_W-1:0] nbr_count;

    always_comb
    begin
        nbr_count = '0;
        for (int x = 0; x < 3; x++)
        begin
            for (int y = 0; y < 3; y++)
            begin
                if (!(x == 1 && y == 1))
                begin
                    nbr_count = nbr_count + NBR_W'(win[x][y]);
                end
            end
        end
    end

    assign alive = (nbr_count == BIRTH_COUNT) ||
                   (win[1][1] && (nbr_count == SURVIVE_COUNT));

endmodule

### design/life_automaton_generation_stream_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_automaton_generation_stream_core
// Next generation of a Conway B3/S23 grid, streamed one cell at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, cell_alive) takes the current
//   generation in raster order, one cell per transaction, row by row.
//   Output channel (out_valid/out_ready) gives one next-generation cell per
//   transaction with its row and column; frame_last marks the final cell of
//   the frame, which also carries frame_live_count.
//   Configuration writes (cfg_write, cfg_index, cfg_data) set the columns and
//   rows in use; a write to either register restarts the frame.
//   Throughput: one cell per cycle while out_ready is high and no flush runs.
//   A cell's result leaves once the cell diagonally below-right (for the last
//   column, the first cell two rows down) has been accepted. After the last
//   cell of a frame in_ready stays low while zero padding is fed through the
//   line stores to flush the remaining results, which adds frame overhead.
//   Latency is set by the line-store read register and the output register.
//   Out_ready low holds the output register; the cell stage then holds and
//   in_ready drops, without loss. Reset sets 32 x 32 (clamped to the
//   parameters) and restarts the frame; line stores are not cleared.
// ----------------------------------------------------------------------------
module life_automaton_generation_stream_core #(
    parameter int MAX_COLS = lags_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = lags_pkg::DEF_MAX_ROWS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [lags_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lags_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               cell_alive,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               next_alive,
    output logic [lags_pkg::CELL_ROW_W-1:0]    cell_row,
    output logic [lags_pkg::CELL_COL_W-1:0]    cell_col,
    output logic                               frame_last,
    output logic [lags_pkg::LIVE_CNT_W-1:0]    frame_live_count
);
    import lags_pkg::*;

    localparam int COL_IDX_W = $clog2(MAX_COLS);
    localparam int ROW_IDX_W = $clog2(MAX_ROWS);
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 2);
    localparam int COL_LAST_RST = ((RST_COLS > MAX_COLS) ? MAX_COLS : RST_COLS) - 1;
    localparam int ROW_LAST_RST = ((RST_ROWS > MAX_ROWS) ? MAX_ROWS : RST_ROWS) - 1;

    // configuration
    logic [COL_IDX_W-1:0] col_last_reg;
    logic [ROW_IDX_W-1:0] row_last_reg;
    logic                 cfg_hit;
    logic [COLS_W-1:0]    cols_val;
    logic [ROWS_W-1:0]    rows_val;
    logic [COL_IDX_W-1:0] col_last_next;
    logic [ROW_IDX_W-1:0] row_last_next;

    // issue position
    logic [ROW_CNT_W-1:0] pos_row_reg;
    logic [COL_IDX_W-1:0] pos_col_reg;
    logic                 flush_reg;
    logic                 issue;
    logic                 issue_bit;
    logic                 last_real;
    logic                 fin_step;
    logic                 at_row_end;

    // cell stage
    logic                 s1_valid_reg;
    logic                 s1_bit_reg;
    logic [ROW_CNT_W-1:0] s1_row_reg;
    logic [COL_IDX_W-1:0] s1_col_reg;
    logic                 s1_fin_reg;
    logic                 s1_emit;
    logic                 s1_go;
    logic                 slot_free;
    logic                 out_free;
    logic                 s1_first_col;

    // line stores: [1] upper, [0] middle
    logic [1:0]           line_mem [MAX_COLS];
    logic [1:0]           mem_rd_reg;
    logic                 byp_valid_reg;
    logic [1:0]           byp_data_reg;
    logic [1:0]           rd_eff;
    logic [1:0]           wr_data;

    // window and rule
    win_t                 win_reg;
    win_t                 eval_win;
    col_t                 new_col;
    logic                 rule_alive;
    logic [ROW_CNT_W-1:0] ctr_row;
    logic [COL_IDX_W-1:0] ctr_col;

    // tally and output
    logic [LIVE_CNT_W-1:0] tally_reg;
    logic [LIVE_CNT_W-1:0] tally_sum;
    logic                  out_valid_reg;
    logic                  next_alive_reg;
    logic [CELL_ROW_W-1:0] cell_row_reg;
    logic [CELL_COL_W-1:0] cell_col_reg;
    logic                  frame_last_reg;
    logic [LIVE_CNT_W-1:0] live_count_reg;

    // configuration decode, clamped to the grid limits
    assign cfg_hit  = cfg_write &&
                      ((cfg_index == REG_COLS_IN_USE) || (cfg_index == REG_ROWS_IN_USE));
    assign cols_val = cfg_data[COLS_W-1:0];
    assign rows_val = cfg_data[ROWS_W-1:0];

    always_comb
    begin
        if (cols_val == '0)
        begin
            col_last_next = '0;
        end
        else if (cols_val > COLS_W'(MAX_COLS))
        begin
            col_last_next = COL_IDX_W'(MAX_COLS - 1);
        end
        else
        begin
            col_last_next = COL_IDX_W'(cols_val - COLS_W'(1));
        end

        if (rows_val == '0)
        begin
            row_last_next = '0;
        end
        else if (rows_val > ROWS_W'(MAX_ROWS))
        begin
            row_last_next = ROW_IDX_W'(MAX_ROWS - 1);
        end
        else
        begin
            row_last_next = ROW_IDX_W'(rows_val - ROWS_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg <= COL_IDX_W'(COL_LAST_RST);
            row_last_reg <= ROW_IDX_W'(ROW_LAST_RST);
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_COLS_IN_USE)
            begin
                col_last_reg <= col_last_next;
            end
            else if (cfg_index == REG_ROWS_IN_USE)
            begin
                row_last_reg <= row_last_next;
            end
        end
    end

    // centre of the cell stage; first column closes the previous row
    assign s1_first_col = (s1_col_reg == '0);
    assign ctr_row      = s1_first_col ? (s1_row_reg - ROW_CNT_W'(2))
                                       : (s1_row_reg - ROW_CNT_W'(1));
    assign ctr_col      = s1_first_col ? col_last_reg : (s1_col_reg - COL_IDX_W'(1));
    assign s1_emit      = s1_first_col ? (s1_row_reg >= ROW_CNT_W'(2))
                                       : (s1_row_reg >= ROW_CNT_W'(1));

    assign out_free  = !out_valid_reg || out_ready;
    assign s1_go     = s1_valid_reg && (!s1_emit || out_free);
    assign slot_free = !s1_valid_reg || s1_go;

    assign in_ready  = slot_free && !flush_reg;
    assign issue     = flush_reg ? slot_free : (in_valid && in_ready);
    assign issue_bit = flush_reg ? 1'b0 : cell_alive;

    assign at_row_end = (pos_col_reg == col_last_reg);
    assign last_real  = !flush_reg && at_row_end &&
                        (pos_row_reg == ROW_CNT_W'(row_last_reg));
    assign fin_step   = flush_reg && (pos_col_reg == '0) &&
                        (pos_row_reg == (ROW_CNT_W'(row_last_reg) + ROW_CNT_W'(2)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_row_reg  <= '0;
            pos_col_reg  <= '0;
            flush_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else if (cfg_hit)
        begin
            pos_row_reg  <= '0;
            pos_col_reg  <= '0;
            flush_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                s1_valid_reg <= 1'b1;
                if (fin_step)
                begin
                    pos_row_reg <= '0;
                    pos_col_reg <= '0;
                    flush_reg   <= 1'b0;
                end
                else
                begin
                    if (at_row_end)
                    begin
                        pos_col_reg <= '0;
                        pos_row_reg <= pos_row_reg + ROW_CNT_W'(1);
                    end
                    else
                    begin
                        pos_col_reg <= pos_col_reg + COL_IDX_W'(1);
                    end
                    flush_reg <= flush_reg || last_real;
                end
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_bit_reg    <= issue_bit;
            s1_row_reg    <= pos_row_reg;
            s1_col_reg    <= pos_col_reg;
            s1_fin_reg    <= fin_step;
            byp_valid_reg <= s1_valid_reg && (s1_col_reg == pos_col_reg);
            byp_data_reg  <= wr_data;
        end
    end

    // line stores, one registered read and one write per cycle
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            mem_rd_reg <= line_mem[pos_col_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            line_mem[s1_col_reg] <= wr_data;
        end
    end

    assign rd_eff  = byp_valid_reg ? byp_data_reg : mem_rd_reg;
    assign wr_data = {rd_eff[0], s1_bit_reg};

    // rows above the grid read as dead
    assign new_col[0] = rd_eff[1] && (s1_row_reg >= ROW_CNT_W'(2));
    assign new_col[1] = rd_eff[0] && (s1_row_reg >= ROW_CNT_W'(1));
    assign new_col[2] = s1_bit_reg;

    assign eval_win[0] = win_reg[1];
    assign eval_win[1] = win_reg[2];
    assign eval_win[2] = s1_first_col ? col_t'(3'b000) : new_col;

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            win_reg[0] <= s1_first_col ? col_t'(3'b000) : win_reg[1];
            win_reg[1] <= s1_first_col ? col_t'(3'b000) : win_reg[2];
            win_reg[2] <= new_col;
        end
    end

    lags_rule u_rule (
        .win   (eval_win),
        .alive (rule_alive)
    );

    assign tally_sum = tally_reg + LIVE_CNT_W'(rule_alive);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_hit)
            begin
                tally_reg <= '0;
            end
            else if (s1_go && s1_emit)
            begin
                tally_reg <= s1_fin_reg ? '0 : tally_sum;
            end

            if (s1_go && s1_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit)
        begin
            next_alive_reg <= rule_alive;
            cell_row_reg   <= CELL_ROW_W'(ctr_row);
            cell_col_reg   <= CELL_COL_W'(ctr_col);
            frame_last_reg <= s1_fin_reg;
            live_count_reg <= s1_fin_reg ? tally_sum : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign next_alive       = next_alive_reg;
    assign cell_row         = cell_row_reg;
    assign cell_col         = cell_col_reg;
    assign frame_last       = frame_last_reg;
    assign frame_live_count = live_count_reg;

endmodule
